// ===== hw/rtl/ffp_pkg.sv =====
// ----------------------------------------------------------------------------
// ffp_pkg: shared types and constants for the fundamental matrix block
// Holds field widths, the cyclic row tables and the queue word format.
// ----------------------------------------------------------------------------
`default_nettype none

package ffp_pkg;

	localparam int EntryWidth   = 16;
	localparam int FractionBits = 12;
	localparam int ResultShift  = 3 * FractionBits;
	localparam int MinorWidth   = 2 * EntryWidth + 1;
	localparam int ProdWidth    = 2 * MinorWidth;
	localparam int AccWidth     = ProdWidth + 4;

	typedef logic signed [EntryWidth-1:0] elem_t;
	typedef logic signed [MinorWidth-1:0] minor_t;
	typedef logic signed [ProdWidth-1:0]  prod_t;
	typedef logic signed [AccWidth-1:0]   acc_t;

	// One queued word: a request for the nine entries. Matrices are
	// snapshotted into the back end when the request is taken.
	typedef struct packed {
		logic [11:0][EntryWidth-1:0] first_m;
		logic [11:0][EntryWidth-1:0] second_m;
	} req_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MINOR,
		BK_PROD,
		BK_OUT
	} bk_state_t;

	function automatic logic [1:0] next_row(input logic [1:0] r);
		case (r)
			2'd0:    next_row = 2'd1;
			2'd1:    next_row = 2'd2;
			default: next_row = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] after_next_row(input logic [1:0] r);
		case (r)
			2'd0:    after_next_row = 2'd2;
			2'd1:    after_next_row = 2'd0;
			default: after_next_row = 2'd1;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ffp_front.sv =====
// ----------------------------------------------------------------------------
// ffp_front: element loader
// Stores each accepted element and hands a compute request to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ffp_front import ffp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             stall,
	input  wire logic        matrix_select,
	input  wire logic [1:0]  row_index,
	input  wire logic [1:0]  column_index,
	input  wire logic [15:0] element_value,
	input  wire logic        compute_now,
	output logic             req_valid,
	input  wire logic        req_stall,
	output req_t             req
);

	logic [11:0][EntryWidth-1:0] first_q, second_q, first_d, second_d;
	logic [3:0] addr;
	logic       acc;

	assign stall = req_stall;
	assign acc   = valid && !stall;
	assign addr  = {row_index, 2'b00} + {2'b00, column_index};

	// Forward the element being written so the request sees it.
	always_comb begin
		first_d  = first_q;
		second_d = second_q;
		if (row_index != 2'd3) begin
			if (matrix_select) second_d[addr] = element_value[EntryWidth-1:0];
			else               first_d[addr]  = element_value[EntryWidth-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
		end else if (acc) begin
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

	assign req_valid     = acc && compute_now;
	assign req.first_m   = first_d;
	assign req.second_m  = second_d;

endmodule

`default_nettype wire

// ===== hw/rtl/ffp_queue.sv =====
// ----------------------------------------------------------------------------
// ffp_queue: two-entry request queue
// Decouples the loader from the determinant engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ffp_queue import ffp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_stall,
	input  req_t      wr_data,
	output logic      rd_valid,
	input  wire logic rd_take,
	output req_t      rd_data
);

	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_stall = (cnt_q == 2'd2);
	assign push     = wr_valid && !wr_stall;
	assign rd_valid = (cnt_q != 2'd0);
	assign pop      = rd_take && rd_valid;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("queue count did not track push");

endmodule

`default_nettype wire

// ===== hw/rtl/ffp_back.sv =====
// ----------------------------------------------------------------------------
// ffp_back: determinant engine
// Computes nine 4x4 determinants by Laplace expansion over 2x2 minor pairs,
// one minor-pair product per step; a new request is taken only once idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffp_back import ffp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_take,
	input  req_t             req,
	output logic             valid,
	input  wire logic        stall,
	output logic [1:0]       out_row,
	output logic [1:0]       out_column,
	output logic [31:0]      entry_value,
	output logic             last_entry
);

	bk_state_t  st_q, st_d;
	logic [11:0][EntryWidth-1:0] f_q, s_q;
	logic [1:0] r_q, c_q;
	logic [2:0] k_q;
	minor_t     ma_q, mb_q;
	prod_t      p_q;
	acc_t       acc_q;
	logic       neg_q;
	logic       oval_q;
	logic [1:0] orow_q, ocol_q;
	logic [31:0] oent_q;
	logic       olast_q;

	logic [1:0] t0, t1, b0, b1, ia, ja, ib, jb;
	logic       sub;
	minor_t     ma_d, mb_d;
	acc_t       sum, shifted;
	logic [31:0] sat;
	logic       out_free;

	// Column pairs per step and the pair of the complementary minor.
	always_comb begin
		case (k_q)
			3'd0:    begin ia = 2'd0; ja = 2'd1; ib = 2'd2; jb = 2'd3; sub = 1'b0; end
			3'd1:    begin ia = 2'd0; ja = 2'd2; ib = 2'd1; jb = 2'd3; sub = 1'b1; end
			3'd2:    begin ia = 2'd0; ja = 2'd3; ib = 2'd1; jb = 2'd2; sub = 1'b0; end
			3'd3:    begin ia = 2'd1; ja = 2'd2; ib = 2'd0; jb = 2'd3; sub = 1'b0; end
			3'd4:    begin ia = 2'd1; ja = 2'd3; ib = 2'd0; jb = 2'd2; sub = 1'b1; end
			default: begin ia = 2'd2; ja = 2'd3; ib = 2'd0; jb = 2'd1; sub = 1'b0; end
		endcase
	end

	function automatic minor_t minor(input elem_t a, input elem_t b,
	                                 input elem_t c, input elem_t d);
		minor = MinorWidth'(a * b) - MinorWidth'(c * d);
	endfunction

	assign t0 = next_row(c_q);
	assign t1 = after_next_row(c_q);
	assign b0 = next_row(r_q);
	assign b1 = after_next_row(r_q);

	assign ma_d = minor(s_q[{t0, ia}], s_q[{t1, ja}], s_q[{t0, ja}], s_q[{t1, ia}]);
	assign mb_d = minor(f_q[{b0, ib}], f_q[{b1, jb}], f_q[{b0, jb}], f_q[{b1, ib}]);

	assign sum     = neg_q ? acc_q - AccWidth'(p_q) : acc_q + AccWidth'(p_q);
	assign shifted = sum >>> ResultShift;
	always_comb begin
		if (shifted > acc_t'(32'sh7FFFFFFF))       sat = 32'h7FFFFFFF;
		else if (shifted < -acc_t'(33'sh80000000)) sat = 32'h80000000;
		else                                       sat = shifted[31:0];
	end

	assign out_free = !oval_q || !stall;
	assign req_take = (st_q == BK_IDLE) && req_valid;

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE:  if (req_valid) st_d = BK_MINOR;
			BK_MINOR: st_d = BK_PROD;
			BK_PROD:  st_d = (k_q == 3'd5) ? BK_OUT : BK_MINOR;
			BK_OUT:   if (out_free) st_d = (r_q == 2'd2 && c_q == 2'd2) ? BK_IDLE : BK_MINOR;
			default:  st_d = BK_IDLE;
		endcase
	end

	// The result register is loaded only when it is free, so a stalled word
	// holds still.
	always_ff @(posedge clk) begin
		case (st_q)
			BK_IDLE: begin
				f_q <= req.first_m;
				s_q <= req.second_m;
				acc_q <= '0;
			end
			BK_MINOR: begin
				ma_q  <= ma_d;
				mb_q  <= mb_d;
				neg_q <= sub;
				if (k_q != 3'd0) acc_q <= sum;
			end
			BK_PROD: p_q <= ma_q * mb_q;
			BK_OUT: if (out_free) begin
				acc_q   <= '0;
				orow_q  <= r_q;
				ocol_q  <= c_q;
				oent_q  <= sat;
				olast_q <= (r_q == 2'd2 && c_q == 2'd2);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_IDLE;
			r_q    <= 2'd0;
			c_q    <= 2'd0;
			k_q    <= 3'd0;
			oval_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (oval_q && !stall) oval_q <= 1'b0;
			case (st_q)
				BK_IDLE: begin r_q <= 2'd0; c_q <= 2'd0; k_q <= 3'd0; end
				BK_PROD: if (k_q != 3'd5) k_q <= k_q + 3'd1;
				BK_OUT: if (out_free) begin
					oval_q <= 1'b1;
					k_q    <= 3'd0;
					if (c_q == 2'd2) begin
						c_q <= 2'd0;
						r_q <= r_q + 2'd1;
					end else begin
						c_q <= c_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	assign valid       = oval_q;
	assign out_row     = orow_q;
	assign out_column  = ocol_q;
	assign entry_value = oent_q;
	assign last_entry  = olast_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid && stall |=> valid && $stable(entry_value))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && last_entry |-> out_row == 2'd2 && out_column == 2'd2)
		else $error("last flag on wrong entry");
	assert property (@(posedge clk) disable iff (!arst_n) k_q <= 3'd5)
		else $error("step counter out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/fundamental_from_projections_core.sv =====
// ----------------------------------------------------------------------------
// fundamental_from_projections_core: fundamental matrix from two cameras
// Loads two 3x4 projection matrices and emits the nine fundamental entries.
// ----------------------------------------------------------------------------
// Element words are accepted while the request queue has room; the input stalls when it is full.
// A compute word yields nine result words; each entry runs six terms through the
// minor multipliers and the product multiplier (a minor step, then a product step),
// then an output step that waits while the output is stalled.
// Reset clears both stored matrices to zero and empties queue and engine.
`default_nettype none

module fundamental_from_projections_core import ffp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        matrix_select,
	input  wire logic [1:0]  row_index,
	input  wire logic [1:0]  column_index,
	input  wire logic [15:0] element_value,
	input  wire logic        compute_now,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       out_row,
	output logic [1:0]       out_column,
	output logic [31:0]      entry_value,
	output logic             last_entry
);

	// Front end: stores elements and raises requests.
	logic q_wvalid, q_wstall, q_rvalid, q_take;
	req_t q_wdata, q_rdata;

	ffp_front u_front (
		.clk, .arst_n,
		.valid(in_valid), .stall(in_stall),
		.matrix_select, .row_index, .column_index, .element_value, .compute_now,
		.req_valid(q_wvalid), .req_stall(q_wstall), .req(q_wdata)
	);

	// The queue lets loading continue while the engine works.
	ffp_queue u_queue (
		.clk, .arst_n,
		.wr_valid(q_wvalid), .wr_stall(q_wstall), .wr_data(q_wdata),
		.rd_valid(q_rvalid), .rd_take(q_take), .rd_data(q_rdata)
	);

	// Back end: nine determinants per request.
	ffp_back u_back (
		.clk, .arst_n,
		.req_valid(q_rvalid), .req_take(q_take), .req(q_rdata),
		.valid(out_valid), .stall(out_stall),
		.out_row, .out_column, .entry_value, .last_entry
	);

endmodule

`default_nettype wire

// ===== tb/fundamental_from_projections_core_tb.sv =====
// ----------------------------------------------------------------------------
// fundamental_from_projections_core_tb: self-checking bench for the core
// Loads projection matrices through the element port, asks for the nine
// fundamental entries, and compares every result word with a local predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module fundamental_from_projections_core_tb;
	import ffp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Shape of one expected result word.
	typedef struct {
		logic [1:0]  row;
		logic [1:0]  col;
		logic [31:0] value;
		logic        last;
	} entry_t;

	// One row of the directed table. When has_value is set, the nine
	// entries that follow are all expected to equal fixed_value, which
	// is easy to see by hand (zero matrices, saturation).
	typedef struct {
		logic        sel;
		logic [1:0]  row;
		logic [1:0]  col;
		logic [15:0] value;
		logic        go;
		logic        has_value;
		logic [31:0] fixed_value;
	} stim_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        matrix_select;
	logic [1:0]  row_index;
	logic [1:0]  column_index;
	logic [15:0] element_value;
	logic        compute_now;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  out_row;
	logic [1:0]  out_column;
	logic [31:0] entry_value;
	logic        last_entry;

	// The predictor keeps its own copy of both stored matrices.
	longint cam_a [12];
	longint cam_b [12];
	entry_t pending_entries [$];
	int     mismatches;
	int     cycle_count;
	bit     hold_long;

	fundamental_from_projections_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.matrix_select(matrix_select), .row_index(row_index),
		.column_index(column_index), .element_value(element_value),
		.compute_now(compute_now),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_row(out_row), .out_column(out_column),
		.entry_value(entry_value), .last_entry(last_entry)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// 2x2 minor of columns i and j from two rows held at offsets a and b.
	function automatic longint minor_of(input longint m [12], input int a, input int b,
			input int i, input int j);
		return m[a + i] * m[b + j] - m[a + j] * m[b + i];
	endfunction

	// Exact 4x4 determinant by Laplace over 2x2 minors, then the Q.12
	// rescale and the clamp to 32 bits.
	function automatic logic [31:0] fundamental_entry(input int r, input int c);
		logic signed [127:0] acc;
		logic signed [127:0] lim_hi;
		logic signed [127:0] lim_lo;
		int t0, t1, b0, b1;
		t0 = 4 * ((c + 1) % 3);
		t1 = 4 * ((c + 2) % 3);
		b0 = 4 * ((r + 1) % 3);
		b1 = 4 * ((r + 2) % 3);
		acc = 0;
		acc += 128'(signed'(minor_of(cam_b, t0, t1, 0, 1))) * minor_of(cam_a, b0, b1, 2, 3);
		acc -= 128'(signed'(minor_of(cam_b, t0, t1, 0, 2))) * minor_of(cam_a, b0, b1, 1, 3);
		acc += 128'(signed'(minor_of(cam_b, t0, t1, 0, 3))) * minor_of(cam_a, b0, b1, 1, 2);
		acc += 128'(signed'(minor_of(cam_b, t0, t1, 1, 2))) * minor_of(cam_a, b0, b1, 0, 3);
		acc -= 128'(signed'(minor_of(cam_b, t0, t1, 1, 3))) * minor_of(cam_a, b0, b1, 0, 2);
		acc += 128'(signed'(minor_of(cam_b, t0, t1, 2, 3))) * minor_of(cam_a, b0, b1, 0, 1);
		acc = acc >>> ResultShift;
		lim_hi = 128'sh7FFF_FFFF;
		lim_lo = -128'sh8000_0000;
		if (acc > lim_hi)
			return 32'h7FFF_FFFF;
		if (acc < lim_lo)
			return 32'h8000_0000;
		return acc[31:0];
	endfunction

	// Applies one accepted element word to the local matrices and queues
	// the nine entries when a compute is requested. A row index of three
	// is dropped but still honors the compute flag.
	task automatic apply_element(input stim_t s);
		entry_t e;
		if (s.row != 2'd3) begin
			if (s.sel)
				cam_b[4 * s.row + s.col] = longint'(signed'(s.value));
			else
				cam_a[4 * s.row + s.col] = longint'(signed'(s.value));
		end
		if (s.go) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					e.row = 2'(r);
					e.col = 2'(c);
					e.value = fundamental_entry(r, c);
					e.last = (r == 2 && c == 2);
					if (s.has_value && e.value !== s.fixed_value) begin
						$error("table value: expected %h, predictor %h", s.fixed_value,
							e.value);
						mismatches++;
					end
					pending_entries.push_back(e);
				end
			end
		end
	endtask

	// Presents one word and holds it until the block takes it. Valid is
	// dropped only for the idle cycles in front of a word.
	task automatic send_element(input stim_t s);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		matrix_select <= s.sel;
		row_index     <= s.row;
		column_index  <= s.col;
		element_value <= s.value;
		compute_now   <= s.go;
		do @(posedge clk); while (in_stall);
		apply_element(s);
	endtask

	function automatic stim_t make_word(input logic sel, input logic [1:0] row,
			input logic [1:0] col, input logic [15:0] value, input logic go);
		stim_t s;
		s.sel = sel; s.row = row; s.col = col; s.value = value; s.go = go;
		s.has_value = 1'b0; s.fixed_value = '0;
		return s;
	endfunction

	// Receiver: random stalls per word, plus one long hold-off while the
	// sender keeps pushing compute requests.
	initial begin
		int wait_cycles;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			wait_cycles = $urandom_range(0, 4);
			if ($urandom_range(0, 7) == 0)
				wait_cycles = 0;
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (600) @(posedge clk);
				hold_long = 1'b0;
			end else if (wait_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Checker: samples at the edge where a word is accepted.
	always @(posedge clk) begin
		entry_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_entries.size() == 0) begin
				$error("unexpected result word row %0d column %0d", out_row, out_column);
				mismatches++;
			end else begin
				e = pending_entries.pop_front();
				if (out_row !== e.row) begin
					$error("out_row: expected %0d, actual %0d", e.row, out_row);
					mismatches++;
				end
				if (out_column !== e.col) begin
					$error("out_column: expected %0d, actual %0d", e.col, out_column);
					mismatches++;
				end
				if (entry_value !== e.value) begin
					$error("entry_value: expected %h, actual %h", e.value, entry_value);
					mismatches++;
				end
				if (last_entry !== e.last) begin
					$error("last_entry: expected %0d, actual %0d", e.last, last_entry);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: stops a run that hangs and reports mismatches.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 800000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		stim_t directed [$];
		stim_t s;
		int    n_items;
		int    settle;
		bit    hold_done;
		mismatches    = 0;
		cycle_count   = 0;
		hold_long     = 1'b0;
		hold_done     = 1'b0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		matrix_select = 1'b0;
		row_index     = '0;
		column_index  = '0;
		element_value = '0;
		compute_now   = 1'b0;
		for (int i = 0; i < 12; i++) begin
			cam_a[i] = 0;
			cam_b[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Right after reset both matrices are zero, so
		// every entry is zero; a dropped row-three word also computes.
		s = make_word(1'b0, 2'd3, 2'd3, 16'hFFFF, 1'b1);
		s.has_value = 1'b1; s.fixed_value = 32'h0;
		directed.push_back(s);
		// Extreme elements: load full-scale values into both matrices.
		for (int i = 0; i < 12; i++) begin
			directed.push_back(make_word(1'b0, 2'(i / 4), 2'(i % 4),
				(i % 3 == 0) ? 16'h8000 : 16'h7FFF, 1'b0));
			directed.push_back(make_word(1'b1, 2'(i / 4), 2'(i % 4),
				(i % 2 == 0) ? 16'h8000 : 16'h7FFF, 1'b0));
		end
		directed.push_back(make_word(1'b1, 2'd2, 2'd3, 16'h8000, 1'b1));
		foreach (directed[i])
			send_element(directed[i]);

		// Random part: mostly full matrix loads followed by a compute,
		// some sparse updates and stray row-three words mixed in.
		n_items = 0;
		while (n_items < 500) begin
			if ($urandom_range(0, 3) != 0) begin
				for (int i = 0; i < 24; i++) begin
					s = make_word(1'(i / 12), 2'((i % 12) / 4), 2'(i % 4),
						16'($urandom()), 1'b0);
					if ($urandom_range(0, 3) == 0)
						s.value = {{5{s.value[15]}}, s.value[10:0]};
					send_element(s);
				end
				n_items += 24;
			end else begin
				s = make_word(1'($urandom()), 2'($urandom_range(0, 3)),
					2'($urandom()), 16'($urandom()), 1'b0);
				send_element(s);
				n_items++;
			end
			s = make_word(1'($urandom()), 2'($urandom_range(0, 3)), 2'($urandom()),
				16'($urandom()), 1'b1);
			send_element(s);
			n_items++;
			// Once, hold the receiver off and keep firing compute words so
			// the request queue fills and the input stalls.
			if (n_items > 250 && !hold_done) begin
				hold_done = 1'b1;
				hold_long = 1'b1;
				for (int i = 0; i < 12; i++) begin
					s = make_word(1'($urandom()), 2'($urandom_range(0, 2)), 2'($urandom()),
						16'($urandom()), 1'b1);
					send_element(s);
				end
				n_items += 12;
			end
		end
		in_valid <= 1'b0;

		while (pending_entries.size() != 0) @(posedge clk);
		settle = 200;
		repeat (settle) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
